/* src/cspk_pkg.sv */
// shared types and constants for the code/symbol bit packer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package cspk_pkg;

   localparam int DEFAULT_CODE_WIDTH = 16;
   localparam int CODE_FIELD_W       = 16;
   localparam int LEN_W              = 5;
   localparam int SYM_W              = 8;
   localparam int BYTE_W             = 8;
   localparam int RES_W              = 7;
   localparam int RES_CNT_W          = 3;
   // residual + longest code + symbol
   localparam int ACC_W              = RES_W + CODE_FIELD_W + SYM_W;
   localparam int MAX_BYTES          = 3;
   localparam int BYTES_W            = MAX_BYTES * BYTE_W;
   localparam int REQ_DATA_W         = 32;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic {
      FUNC_PACK  = 1'b0,
      FUNC_FLUSH = 1'b1
   } func_type;

   // one queued unit of work: up to three bytes, lowest byte first
   typedef struct packed {
      logic [BYTES_W-1:0] bytes;
      logic [1:0]         count_m1;
   } entry_type;

endpackage

/* src/cspk_front.sv */
// front end: accepts pack/flush transactions, keeps the residual bits,
// and forms byte groups for the queue; depends on cspk_pkg
`timescale 1ns / 1ps

module cspk_front #(
   parameter int CODE_WIDTH = cspk_pkg::DEFAULT_CODE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  cspk_pkg::func_type                in_func,
   input  logic [cspk_pkg::CODE_FIELD_W-1:0] in_code,
   input  logic [cspk_pkg::LEN_W-1:0]        in_len,
   input  logic [cspk_pkg::SYM_W-1:0]        in_sym,
   output logic                              push,
   output cspk_pkg::entry_type               push_entry,
   input  logic                              queue_full
);
   import cspk_pkg::*;

   localparam int LEN_LIMIT_INT = (CODE_WIDTH < CODE_FIELD_W) ? CODE_WIDTH : CODE_FIELD_W;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_INT);

   logic [RES_W-1:0]        residual_bits_ff, residual_bits_in;
   logic [RES_CNT_W-1:0]    residual_count_ff, residual_count_in;
   logic                    accept;
   logic [LEN_W-1:0]        len_sat;
   logic [CODE_FIELD_W-1:0] code_masked;
   logic [ACC_W-1:0]        acc;
   logic [LEN_W-1:0]        total;
   logic [1:0]              nbytes;
   logic [ACC_W-1:0]        acc_rest;
   logic [RES_W-1:0]        res_mask;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      len_sat     = (in_len > LEN_LIMIT) ? LEN_LIMIT : in_len;
      code_masked = in_code & ~({CODE_FIELD_W{1'b1}} << len_sat);
      acc = ACC_W'(residual_bits_ff)
          | (ACC_W'(code_masked) << residual_count_ff)
          | (ACC_W'(in_sym) << (LEN_W'(residual_count_ff) + len_sat));
      total  = LEN_W'(residual_count_ff) + len_sat + LEN_W'(BYTE_W);
      nbytes = total[LEN_W-1:3];
      unique case (nbytes)
         2'd1:    acc_rest = acc >> BYTE_W;
         2'd2:    acc_rest = acc >> (2 * BYTE_W);
         default: acc_rest = acc >> (3 * BYTE_W);
      endcase
      res_mask = ~({RES_W{1'b1}} << total[2:0]);
   end

   always_comb begin
      push_entry        = '0;
      push              = 1'b0;
      residual_bits_in  = residual_bits_ff;
      residual_count_in = residual_count_ff;
      if (accept) begin
         if (in_func == FUNC_FLUSH) begin
            // partial byte, high bits already zero
            push_entry.bytes    = BYTES_W'(residual_bits_ff);
            push_entry.count_m1 = 2'd0;
            push                = (residual_count_ff != '0);
            residual_bits_in    = '0;
            residual_count_in   = '0;
         end else begin
            push_entry.bytes    = acc[BYTES_W-1:0];
            push_entry.count_m1 = nbytes - 2'd1;
            push                = 1'b1;
            residual_bits_in    = acc_rest[RES_W-1:0] & res_mask;
            residual_count_in   = total[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residual_bits_ff  <= '0;
         residual_count_ff <= '0;
      end else begin
         residual_bits_ff  <= residual_bits_in;
         residual_count_ff <= residual_count_in;
      end
   end

endmodule

/* src/cspk_queue.sv */
// small fifo of byte groups between front and back end
// depends on cspk_pkg
`timescale 1ns / 1ps

module cspk_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cspk_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output cspk_pkg::entry_type head_entry
);
   import cspk_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* src/cspk_back.sv */
// back end: walks the head byte group one byte per cycle into the
// registered output stage while out_ready does not stall it; depends on cspk_pkg
`timescale 1ns / 1ps

module cspk_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  cspk_pkg::entry_type        head_entry,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [cspk_pkg::BYTE_W-1:0] out_byte,
   output logic                       out_last
);
   import cspk_pkg::*;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic [1:0]        idx_ff, idx_in;
   logic              load;
   logic              is_last;

   assign load    = head_valid && (!out_valid_ff || out_ready);
   assign is_last = (idx_ff == head_entry.count_m1);
   assign pop     = load && is_last;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = head_entry.bytes[idx_ff * BYTE_W +: BYTE_W];
         out_last_in  = is_last;
         idx_in       = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

endmodule

/* src/code_symbol_bit_packer.sv */
// top level of the code/symbol bit packer: front end, queue, back end
// depends on cspk_pkg, cspk_front, cspk_queue, cspk_back
`timescale 1ns / 1ps

//  channel | dir | tdata (lsb up)                           | tuser | tlast
//  req_    | in  | code_bits[15:0] code_len[20:16]          | func  | -
//          |     | symbol[28:21], zero pad [31:29]          |       |
//  rsp_    | out | out_byte[7:0]                            | -     | run_last
//
//  a pack transaction yields 1 to 3 bytes, one byte per cycle while rsp_ is not
//  stalled; the back end's byte walk sets the pace
//  a flush yields one byte if bits are held, none otherwise
//  first byte reaches rsp_ through the queue write, then the output register
//  synchronous reset clears the residual, the queue and the output stage
//  the two-entry queue lets the input keep accepting while rsp_ is stalled, until it is full

module code_symbol_bit_packer #(
   parameter int CODE_WIDTH = cspk_pkg::DEFAULT_CODE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cspk_pkg::REQ_DATA_W-1:0] req_tdata,  // code_bits, code_len, symbol
   input  logic                            req_tuser,  // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cspk_pkg::BYTE_W-1:0]     rsp_tdata,  // out_byte
   output logic                            rsp_tlast   // run_last
);
   import cspk_pkg::*;

   // unpack the request fields
   logic [CODE_FIELD_W-1:0] req_code;
   logic [LEN_W-1:0]        req_len;
   logic [SYM_W-1:0]        req_sym;
   func_type                req_func;

   assign req_code = req_tdata[CODE_FIELD_W-1:0];
   assign req_len  = req_tdata[CODE_FIELD_W +: LEN_W];
   assign req_sym  = req_tdata[CODE_FIELD_W + LEN_W +: SYM_W];
   assign req_func = func_type'(req_tuser);

   // front to queue
   logic      push;
   entry_type push_entry;
   logic      queue_full;

   // queue to back
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   cspk_front #(
      .CODE_WIDTH(CODE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_func    (req_func),
      .in_code    (req_code),
      .in_len     (req_len),
      .in_sym     (req_sym),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   cspk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // byte walk and registered output
   cspk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

/* src/cspk_checker.sv */
// port-level checks for the code/symbol bit packer, bound to the top level
// depends on cspk_pkg and code_symbol_bit_packer
`timescale 1ns / 1ps

module cspk_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [cspk_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cspk_pkg::BYTE_W-1:0]     rsp_tdata,
   input logic                            rsp_tlast
);

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("req transaction changed while stalled");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // bytes of one transaction's run come back to back
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a result run");

   // after reset nothing is pending and input is open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

endmodule

bind code_symbol_bit_packer cspk_checker u_cspk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* bench/tb_code_symbol_bit_packer.sv */
// self-checking bench for code_symbol_bit_packer: random and directed pack/flush traffic
// depends on cspk_pkg and the code_symbol_bit_packer rtl; needs no other files
`timescale 1ns / 1ps

module tb_code_symbol_bit_packer;

   import cspk_pkg::*;

   // effective cap on code length: the code width parameter, but never past the field
   localparam int CODE_LIMIT  = (DEFAULT_CODE_WIDTH < CODE_FIELD_W) ?
                                DEFAULT_CODE_WIDTH : CODE_FIELD_W;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 20;

   // one request transaction as the bench sees it
   typedef struct {
      func_type           func;
      logic [15:0]        code_bits;
      logic [LEN_W-1:0]   code_len;
      logic [SYM_W-1:0]   symbol;
   } req_word_type;

   // one expected response transaction
   typedef struct {
      logic [BYTE_W-1:0]  value;
      logic               last;
   } packed_byte_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // code_bits, code_len, symbol
   logic                  req_tuser;   // func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [BYTE_W-1:0]     rsp_tdata;   // out_byte
   logic                  rsp_tlast;   // run_last

   req_word_type    pending_words[$];
   packed_byte_type expected_bytes[$];

   // bench copy of the residual register
   logic [RES_W-1:0]     held_bits  = '0;
   logic [RES_CNT_W-1:0] held_count = '0;

   int  send_idle_pct = 19;
   int  recv_idle_pct = 88;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  req_taken = 1'b0;

   code_symbol_bit_packer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // bit-stream model: appends code then symbol, lsb first, and queues
   // every byte that fills; a flush drains the partial byte if any
   // ------------------------------------------------------------------
   task automatic pack_predict(input func_type func, input logic [15:0] code,
                               input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym);
      int              eff_len;
      int              total;
      int              nbytes;
      logic [31:0]     code_mask;
      logic [31:0]     acc;
      packed_byte_type b;
      if (func == FUNC_FLUSH) begin
         // nothing held means no transaction at all
         if (held_count != 0) begin
            b.value = {1'b0, held_bits};
            b.last  = 1'b1;
            expected_bytes.push_back(b);
            held_bits  = '0;
            held_count = '0;
         end
      end else begin
         // overlong codes saturate
         eff_len = int'(len);
         if (eff_len > CODE_LIMIT) eff_len = CODE_LIMIT;
         code_mask = (32'd1 << eff_len) - 32'd1;
         acc = 32'(held_bits)
             | ((32'(code) & code_mask) << held_count)
             | (32'(sym) << (int'(held_count) + eff_len));
         total  = int'(held_count) + eff_len + BYTE_W;
         nbytes = total / BYTE_W;
         for (int i = 0; i < nbytes; i++) begin
            b.value = acc[i*BYTE_W +: BYTE_W];
            b.last  = (i == nbytes - 1);
            expected_bytes.push_back(b);
         end
         held_count = RES_CNT_W'(total % BYTE_W);
         held_bits  = RES_W'((acc >> (nbytes * BYTE_W)) &
                             ((32'd1 << (total % BYTE_W)) - 32'd1));
      end
   endtask

   task automatic note_mismatch(input string msg);
      if (mismatch_count < 10) $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // request driver: new values only at the falling edge; a word stays
   // on the bus until the rising edge that takes it
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_words[0].func;
               req_tdata  <= {3'b000, pending_words[0].symbol,
                              pending_words[0].code_len, pending_words[0].code_bits};
               void'(pending_words.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         // receiver back-pressure, redrawn every cycle
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // monitor: predict on every accepted request, then check every
   // accepted response against the oldest expected byte
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      packed_byte_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pack_predict(func_type'(req_tuser), req_tdata[15:0], req_tdata[20:16],
                         req_tdata[28:21]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               note_mismatch($sformatf("unexpected byte %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.value || rsp_tlast !== want.last)
                  note_mismatch($sformatf("byte exp %h last %b, got %h last %b",
                                          want.value, want.last, rsp_tdata, rsp_tlast));
            end
         end
      end
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_code_symbol_bit_packer: FAIL");
         $finish;
      end
   end

   task automatic add_word(input func_type func, input logic [15:0] code,
                           input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym);
      req_word_type w;
      w.func      = func;
      w.code_bits = code;
      w.code_len  = len;
      w.symbol    = sym;
      pending_words.push_back(w);
   endtask

   // mostly packs of legal length, some overlong codes, some flushes
   task automatic add_random_words(input int count);
      int              pick;
      logic [LEN_W-1:0] len;
      logic [15:0]      code;
      logic [SYM_W-1:0] sym;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         code = (pick % 9 == 0) ? 16'hFFFF : 16'($urandom);
         sym  = (pick % 11 == 0) ? 8'hFF : 8'($urandom);
         if (pick < 10) begin
            add_word(FUNC_FLUSH, code, 5'($urandom), sym);
         end else begin
            len = (pick < 22) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16, 0));
            add_word(FUNC_PACK, code, len, sym);
         end
      end
   endtask

   // wait until every word went out and every expected byte came back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_bytes.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;

      // directed part
      add_word(FUNC_FLUSH, 16'h0000, 5'd0,  8'h00);  // flush with nothing held
      add_word(FUNC_PACK,  16'hFFFF, 5'd0,  8'h00);  // empty code, code bits masked off
      add_word(FUNC_PACK,  16'hFFFF, 5'd16, 8'hFF);  // longest code, three bytes
      add_word(FUNC_PACK,  16'h0001, 5'd1,  8'hA5);  // leaves one bit held
      add_word(FUNC_PACK,  16'hFFFF, 5'd16, 8'hFF);  // held bit plus longest code
      add_word(FUNC_PACK,  16'hFFFF, 5'd31, 8'h00);  // overlong code saturates
      add_word(FUNC_PACK,  16'h8001, 5'd17, 8'h81);  // just past the cap
      add_word(FUNC_PACK,  16'h003F, 5'd6,  8'h5A);  // builds up to seven held bits
      add_word(FUNC_PACK,  16'hFFFF, 5'd16, 8'hFF);  // seven held plus longest code
      add_word(FUNC_FLUSH, 16'hFFFF, 5'd31, 8'hFF);  // flush with bits held, fields ignored
      add_word(FUNC_FLUSH, 16'h1234, 5'd5,  8'h77);  // second flush is silent
      add_word(FUNC_PACK,  16'hAAAA, 5'd15, 8'h00);
      add_word(FUNC_PACK,  16'h5555, 5'd8,  8'hFF);
      add_word(FUNC_PACK,  16'h0000, 5'd16, 8'h00);
      add_word(FUNC_PACK,  16'hFFFF, 5'd7,  8'h01);
      add_word(FUNC_FLUSH, 16'h0000, 5'd0,  8'h00);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      add_random_words(80);
      wait_drained();

      @(posedge clock);
      send_idle_pct = 88;
      recv_idle_pct = 19;
      add_random_words(85);
      wait_drained();

      @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_words(85);
      add_word(FUNC_FLUSH, 16'h0000, 5'd0, 8'h00);
      wait_drained();

      // let any stray byte surface before the verdict
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_bytes.size() != 0) note_mismatch("bytes still outstanding at end");

      if (mismatch_count == 0) begin
         $display("tb_code_symbol_bit_packer: PASS");
      end else begin
         $display("tb_code_symbol_bit_packer: FAIL");
      end
      $finish;
   end

endmodule
